// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; included by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define KVT_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define KVT_ASSERT_NEXT(lbl, clk, pre, post, rst_n, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that also runs through reset
`define KVT_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/kvt_pkg.sv =====
// types and character constants of the key/value pair tokenizer
// no dependencies; used by every module of the block
package kvt_pkg;

    localparam int CHAR_W = 16;
    localparam int SP_W   = 8;

    // special code units
    localparam logic [CHAR_W-1:0] C_OPEN  = 16'h003C;
    localparam logic [CHAR_W-1:0] C_EQUAL = 16'h003D;
    localparam logic [CHAR_W-1:0] C_CLOSE = 16'h003E;
    localparam logic [CHAR_W-1:0] C_QUOTE = 16'h0022;
    localparam logic [CHAR_W-1:0] C_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] C_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] C_LF    = 16'h000A;

    localparam logic [SP_W-1:0] SP_MAX = 8'd255;

    // scanner phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BKEY,
        PH_KEY,
        PH_AKEY,
        PH_BVAL,
        PH_VAL,
        PH_AVAL
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        K_KEY,
        K_VAL,
        K_DONE,
        K_DROP
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic [SP_W-1:0]   sp;
        logic              last;
    } t_result;

    // results of one input item, handed to the result queue
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// ===== rtl/kvt_scan.sv =====
// scanner state and next-state logic, one code unit per enabled cycle
// depends on kvt_pkg
module kvt_scan import kvt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_eot,
    output t_push             o_push
);

    t_phase          r_phase, n_phase;
    logic            r_in_quotes, n_in_quotes;
    logic            r_quote_pend, n_quote_pend;
    logic [SP_W-1:0] r_held, n_held;

    logic              ctl;
    logic              skip;
    logic              em;
    t_kind             ek;
    logic [CHAR_W-1:0] ec;
    logic [SP_W-1:0]   es;
    logic              do_drop;
    logic              do_done;
    logic              eot_drop;
    t_result           res_scan;
    t_result           res_drop;

    // scan one unit, then apply end of text
    always_comb begin
        n_phase      = r_phase;
        n_in_quotes  = r_in_quotes;
        n_quote_pend = r_quote_pend;
        n_held       = r_held;
        ctl          = (i_char == C_CR) || (i_char == C_LF);
        skip         = 1'b0;
        em           = 1'b0;
        ek           = K_KEY;
        ec           = '0;
        es           = '0;
        do_drop      = 1'b0;
        do_done      = 1'b0;
        eot_drop     = 1'b0;

        // quote inside quotes: doubled quote or closing quote
        if (r_quote_pend) begin
            n_quote_pend = 1'b0;
            if (i_char == C_QUOTE) begin
                em   = 1'b1;
                ek   = (r_phase == PH_KEY) ? K_KEY : K_VAL;
                ec   = C_QUOTE;
                skip = 1'b1;
            end else begin
                n_in_quotes = 1'b0;
                n_phase     = (r_phase == PH_KEY) ? PH_AKEY : PH_AVAL;
            end
        end

        if (!skip) begin
            case (n_phase)
                PH_BKEY: begin
                    if (i_char == C_OPEN || i_char == C_EQUAL || i_char == C_CLOSE || ctl) begin
                        do_drop = 1'b1;
                    end else if (i_char != C_SPACE) begin
                        n_phase = PH_KEY;
                        if (i_char == C_QUOTE) begin
                            n_in_quotes = 1'b1;
                        end else begin
                            em = 1'b1;
                            ek = K_KEY;
                            ec = i_char;
                        end
                    end
                end
                PH_KEY: begin
                    if (n_in_quotes) begin
                        if (i_char == C_QUOTE) begin
                            n_quote_pend = 1'b1;
                        end else begin
                            em = 1'b1;
                            ek = K_KEY;
                            ec = i_char;
                        end
                    end else if (i_char == C_OPEN || i_char == C_QUOTE ||
                                 i_char == C_CLOSE || ctl) begin
                        do_drop = 1'b1;
                    end else if (i_char == C_EQUAL) begin
                        n_held  = '0;
                        n_phase = PH_BVAL;
                    end else if (i_char == C_SPACE) begin
                        n_held = SP_W'(1);
                    end else begin
                        em     = 1'b1;
                        ek     = K_KEY;
                        ec     = i_char;
                        es     = (n_held != '0) ? SP_W'(1) : '0;
                        n_held = '0;
                    end
                end
                PH_AKEY: begin
                    if (i_char == C_EQUAL) begin
                        n_phase = PH_BVAL;
                    end else if (i_char != C_SPACE) begin
                        do_drop = 1'b1;
                    end
                end
                PH_BVAL: begin
                    if (i_char == C_CLOSE) begin
                        do_done = 1'b1;
                    end else if (i_char == C_OPEN || i_char == C_EQUAL || ctl) begin
                        do_drop = 1'b1;
                    end else if (i_char != C_SPACE) begin
                        n_phase = PH_VAL;
                        if (i_char == C_QUOTE) begin
                            n_in_quotes = 1'b1;
                        end else begin
                            em = 1'b1;
                            ek = K_VAL;
                            ec = i_char;
                        end
                    end
                end
                PH_VAL: begin
                    if (n_in_quotes) begin
                        if (i_char == C_QUOTE) begin
                            n_quote_pend = 1'b1;
                        end else begin
                            em = 1'b1;
                            ek = K_VAL;
                            ec = i_char;
                        end
                    end else if (i_char == C_OPEN || i_char == C_QUOTE ||
                                 i_char == C_EQUAL || ctl) begin
                        do_drop = 1'b1;
                    end else if (i_char == C_CLOSE) begin
                        do_done = 1'b1;
                    end else if (i_char == C_SPACE) begin
                        if (n_held != SP_MAX) begin
                            n_held = n_held + 1'b1;
                        end
                    end else begin
                        em     = 1'b1;
                        ek     = K_VAL;
                        ec     = i_char;
                        es     = n_held;
                        n_held = '0;
                    end
                end
                PH_AVAL: begin
                    if (i_char == C_CLOSE) begin
                        do_done = 1'b1;
                    end else if (i_char != C_SPACE) begin
                        do_drop = 1'b1;
                    end
                end
                default: begin
                    // idle, and the unused phase code
                    n_phase = PH_IDLE;
                    if (i_char == C_OPEN) begin
                        n_in_quotes  = 1'b0;
                        n_quote_pend = 1'b0;
                        n_held       = '0;
                        n_phase      = PH_BKEY;
                    end
                end
            endcase
        end

        // invalid unit: drop the pair, rescan from idle, or from a new pair on '<'
        if (do_drop) begin
            em           = 1'b1;
            ek           = K_DROP;
            ec           = '0;
            es           = '0;
            n_in_quotes  = 1'b0;
            n_quote_pend = 1'b0;
            n_held       = '0;
            n_phase      = (i_char == C_OPEN) ? PH_BKEY : PH_IDLE;
        end

        // closing mark: pair complete
        if (do_done) begin
            em           = 1'b1;
            ek           = K_DONE;
            ec           = '0;
            es           = '0;
            n_in_quotes  = 1'b0;
            n_quote_pend = 1'b0;
            n_held       = '0;
            n_phase      = PH_IDLE;
        end

        // end of text drops an unfinished pair
        if (i_eot) begin
            eot_drop     = (n_phase != PH_IDLE);
            n_phase      = PH_IDLE;
            n_in_quotes  = 1'b0;
            n_quote_pend = 1'b0;
            n_held       = '0;
        end
    end

    // pack the results of this unit
    always_comb begin
        res_scan.kind = ek;
        res_scan.ch   = ec;
        res_scan.sp   = es;
        res_scan.last = !eot_drop;
        res_drop.kind = K_DROP;
        res_drop.ch   = '0;
        res_drop.sp   = '0;
        res_drop.last = 1'b1;
        o_push.n      = {1'b0, em} + {1'b0, eot_drop};
        o_push.r0     = em ? res_scan : res_drop;
        o_push.r1     = res_drop;
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_in_quotes  <= 1'b0;
            r_quote_pend <= 1'b0;
            r_held       <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_in_quotes  <= n_in_quotes;
            r_quote_pend <= n_quote_pend;
            r_held       <= n_held;
        end
    end

endmodule

// ===== rtl/kvt_outq.sv =====
// result queue: takes up to two results a cycle, hands out one
// depends on kvt_pkg
module kvt_outq import kvt_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   wp1;
    logic            pop;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // pointer and count update
    always_comb begin
        wp1   = inc(r_wp);
        pop   = o_valid && i_ready;
        n_rp  = pop ? inc(r_rp) : r_rp;
        case (i_push.n)
            2'd1:    n_wp = wp1;
            2'd2:    n_wp = inc(wp1);
            default: n_wp = r_wp;
        endcase
        n_cnt = r_cnt + CW'(i_push.n) - CW'(pop);
    end

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= CW'(DEPTH - 2));
    assign o_item  = r_mem[r_rp];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

endmodule

// ===== rtl/key_value_pair_tokenizer.sv =====
// top level of the key/value pair tokenizer: input register, scanner, result queue
// depends on kvt_pkg, kvt_scan and kvt_outq
//
// Takes one 16-bit code unit per cycle and reports key characters, value
// characters, pair-complete and pair-dropped marks. A unit is held in an
// input register until the queue has room, then scanned in a single pass
// whose results (none, one or two) enter a P_QUEUE_DEPTH-entry result
// queue, whose head is on the output. Input is taken every cycle as long
// as the queue has room for two results, so the sustained rate is one
// unit per cycle, bounded on the output side by one result per cycle when
// units give two results or the consumer stalls.
module key_value_pair_tokenizer import kvt_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] char_code
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] char_code_res, [23:16] spaces_before
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last_of_run
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_eot;
    logic              room;
    logic              process;
    t_push             scan_push;
    t_push             q_push;
    t_result           q_item;

    assign process         = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || process;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_char <= i_s_axis_tdata;
            r_in_eot  <= i_s_axis_tlast;
        end
    end

    kvt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (process),
        .i_char  (r_in_char),
        .i_eot   (r_in_eot),
        .o_push  (scan_push)
    );

    // only push while the item is really taken
    always_comb begin
        q_push   = scan_push;
        q_push.n = process ? scan_push.n : 2'd0;
    end

    kvt_outq #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_item  (q_item)
    );

    assign o_m_axis_tdata = {q_item.sp, q_item.ch};
    assign o_m_axis_tuser = q_item.kind;
    assign o_m_axis_tlast = q_item.last;

endmodule

// ===== rtl/kvt_checker.sv =====
// port-level checks of the key/value pair tokenizer, bound to the top level
// depends on kvt_pkg and assert_macros.svh
`include "assert_macros.svh"

module kvt_checker import kvt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic [1:0]  i_m_tuser,
    input logic        i_m_tlast
);

    // stalled result holds
    `KVT_ASSERT_NEXT(a_hold, i_clk, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), i_rst_n, "stalled result changed")

    // reset empties the result queue
    `KVT_ASSERT_NEXT_ALWAYS(a_reset, i_clk, !i_rst_n, !i_m_tvalid, "result after reset")

    // marks carry no character and no spaces
    `KVT_ASSERT_IMPLY(a_mark, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser == K_DONE || i_m_tuser == K_DROP), i_m_tdata == 24'd0, "mark with payload")

    // key characters carry at most one space
    `KVT_ASSERT_IMPLY(a_keysp, i_clk, i_rst_n, i_m_tvalid && i_m_tuser == K_KEY, i_m_tdata[23:17] == 7'd0, "key spaces above one")

    // input only backs up behind waiting results
    `KVT_ASSERT_IMPLY(a_bp, i_clk, i_rst_n, !i_s_tready, i_m_tvalid, "input stalled with empty output")

endmodule

bind key_value_pair_tokenizer kvt_checker u_kvt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast)
);

// ===== test/tb_key_value_pair_tokenizer.sv =====
// testbench for the key/value pair tokenizer: directed and random text streams
// depends on kvt_pkg and key_value_pair_tokenizer; a scoreboard class predicts every result
`timescale 1ns / 100ps

module tb_key_value_pair_tokenizer;
    import kvt_pkg::*;

    localparam int N_UNITS    = 1450;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_WAIT  = 16;

    // predicts tokenizer results and checks them in order
    class token_scoreboard;
        t_phase          phase;
        logic            in_q;
        logic            q_pend;
        logic [SP_W-1:0] held;
        t_result         step_res[$];
        t_result         exp_tokens[$];
        int              errors;

        function new();
            phase  = PH_IDLE;
            in_q   = 1'b0;
            q_pend = 1'b0;
            held   = '0;
            errors = 0;
        endfunction

        function void put_res(t_kind k, logic [CHAR_W-1:0] c, logic [SP_W-1:0] s);
            t_result r;
            if (step_res.size() >= 2) return;
            r.kind = k;
            r.ch   = c;
            r.sp   = s;
            r.last = 1'b0;
            step_res.push_back(r);
        endfunction

        function void clear_token();
            in_q   = 1'b0;
            q_pend = 1'b0;
            held   = '0;
        endfunction

        // pair dropped; a '<' reopens at once
        function void drop_pair(logic [CHAR_W-1:0] c);
            put_res(K_DROP, '0, '0);
            clear_token();
            phase = (c == C_OPEN) ? PH_BKEY : PH_IDLE;
        endfunction

        function void close_pair();
            put_res(K_DONE, '0, '0);
            clear_token();
            phase = PH_IDLE;
        endfunction

        function void scan_unit(logic [CHAR_W-1:0] c);
            logic ctl;
            ctl = (c == C_CR) || (c == C_LF);
            // quote inside quotes: doubled quote or closing quote
            if (q_pend) begin
                q_pend = 1'b0;
                if (c == C_QUOTE) begin
                    put_res((phase == PH_KEY) ? K_KEY : K_VAL, C_QUOTE, '0);
                    return;
                end
                in_q  = 1'b0;
                phase = (phase == PH_KEY) ? PH_AKEY : PH_AVAL;
            end
            case (phase)
                PH_BKEY: begin
                    if (c == C_OPEN || c == C_EQUAL || c == C_CLOSE || ctl) begin
                        drop_pair(c);
                    end else if (c != C_SPACE) begin
                        phase = PH_KEY;
                        if (c == C_QUOTE) in_q = 1'b1;
                        else put_res(K_KEY, c, '0);
                    end
                end
                PH_KEY: begin
                    if (in_q) begin
                        if (c == C_QUOTE) q_pend = 1'b1;
                        else put_res(K_KEY, c, '0);
                    end else if (c == C_OPEN || c == C_QUOTE || c == C_CLOSE || ctl) begin
                        drop_pair(c);
                    end else if (c == C_EQUAL) begin
                        held  = '0;
                        phase = PH_BVAL;
                    end else if (c == C_SPACE) begin
                        held = 8'd1;
                    end else begin
                        put_res(K_KEY, c, (held != 0) ? 8'd1 : 8'd0);
                        held = '0;
                    end
                end
                PH_AKEY: begin
                    if (c == C_EQUAL) phase = PH_BVAL;
                    else if (c != C_SPACE) drop_pair(c);
                end
                PH_BVAL: begin
                    if (c == C_CLOSE) begin
                        close_pair();
                    end else if (c == C_OPEN || c == C_EQUAL || ctl) begin
                        drop_pair(c);
                    end else if (c != C_SPACE) begin
                        phase = PH_VAL;
                        if (c == C_QUOTE) in_q = 1'b1;
                        else put_res(K_VAL, c, '0);
                    end
                end
                PH_VAL: begin
                    if (in_q) begin
                        if (c == C_QUOTE) q_pend = 1'b1;
                        else put_res(K_VAL, c, '0);
                    end else if (c == C_OPEN || c == C_QUOTE || c == C_EQUAL || ctl) begin
                        drop_pair(c);
                    end else if (c == C_CLOSE) begin
                        close_pair();
                    end else if (c == C_SPACE) begin
                        if (held < SP_MAX) held = held + 8'd1;
                    end else begin
                        put_res(K_VAL, c, held);
                        held = '0;
                    end
                end
                PH_AVAL: begin
                    if (c == C_CLOSE) close_pair();
                    else if (c != C_SPACE) drop_pair(c);
                end
                default: begin
                    phase = PH_IDLE;
                    if (c == C_OPEN) begin
                        clear_token();
                        phase = PH_BKEY;
                    end
                end
            endcase
        endfunction

        // accepted input item: work out its results
        function void note_unit(logic [CHAR_W-1:0] c, logic eot);
            step_res.delete();
            scan_unit(c);
            if (eot) begin
                if (phase != PH_IDLE) put_res(K_DROP, '0, '0);
                phase = PH_IDLE;
                clear_token();
            end
            if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
            foreach (step_res[i]) exp_tokens.push_back(step_res[i]);
        endfunction

        function void cmp_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // accepted result item: compare with the oldest expectation
        function void check_token(logic [1:0] k, logic [CHAR_W-1:0] c, logic [SP_W-1:0] s,
                                  logic l);
            t_result r;
            if (exp_tokens.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d ch %h sp %0d last %0d",
                         $time, k, c, s, l);
                errors++;
                return;
            end
            r = exp_tokens.pop_front();
            cmp_field("kind", r.kind, k);
            cmp_field("char_code", r.ch, c);
            cmp_field("spaces_before", r.sp, s);
            cmp_field("last_of_run", r.last, l);
        endfunction

        function int pending();
            return exp_tokens.size();
        endfunction
    endclass

    logic        i_clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    token_scoreboard sb = new();

    int unsigned units_sent = 0;
    int unsigned burst_left = 0;
    bit          force_long = 1'b1;
    logic [15:0] pair_units[$];

    // {end_of_text, char_code}
    logic [16:0] directed_units[$] = '{
        // unquoted pair: inner key spaces collapse, key trailing space dropped, value spaces counted
        {1'b0, C_OPEN}, {1'b0, 16'h0061}, {1'b0, C_SPACE}, {1'b0, C_SPACE},
        {1'b0, 16'h0062}, {1'b0, C_SPACE}, {1'b0, C_EQUAL}, {1'b0, 16'h0063},
        {1'b0, C_SPACE}, {1'b0, C_SPACE}, {1'b0, 16'h0064}, {1'b0, C_CLOSE},
        // quoted key holding a doubled quote, quoted value holding a line break
        {1'b0, C_OPEN}, {1'b0, C_QUOTE}, {1'b0, C_QUOTE}, {1'b0, C_QUOTE},
        {1'b0, C_QUOTE}, {1'b0, C_EQUAL}, {1'b0, C_QUOTE}, {1'b0, C_CR},
        {1'b0, C_QUOTE}, {1'b0, C_CLOSE},
        // extreme codes, drop with reopen, drop on line break, end of text mid key
        {1'b0, C_OPEN}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, C_OPEN},
        {1'b0, C_LF}, {1'b0, C_OPEN}, {1'b1, 16'h0078}
    };

    key_value_pair_tokenizer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: check accepted items, stall on a changing pattern
    int unsigned rx_mode_left = 0;
    int unsigned rx_mode      = 0;
    int unsigned rx_hold      = 0;
    int unsigned rx_tick      = 0;

    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_tready)
            sb.check_token(o_m_axis_tuser, o_m_axis_tdata[15:0], o_m_axis_tdata[23:16],
                           o_m_axis_tlast);
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= (rx_tick % 4 == 0);
            default: begin
                if (rx_hold != 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= rx_hold - 1;
                end else if ($urandom_range(0, 7) == 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= $urandom_range(4, 24);
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // watchdog on cycles without any accepted item
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // send one item, with bursts and gaps between them
    task automatic send_unit(input logic [15:0] c, input logic eot);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_unit(c, eot);
        burst_left--;
        units_sent++;
    endtask

    // hold the sender until every expected result has come
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] special_char();
        case ($urandom_range(0, 6))
            0: return C_OPEN;
            1: return C_EQUAL;
            2: return C_CLOSE;
            3: return C_QUOTE;
            4: return C_SPACE;
            5: return C_CR;
            default: return C_LF;
        endcase
    endfunction

    // any code unit that is not a special one
    function automatic logic [15:0] plain_char();
        logic [15:0] c;
        do begin
            c = $urandom_range(0, 1) ? 16'($urandom_range(16'h21, 16'h7E)) : 16'($urandom);
        end while (c == C_OPEN || c == C_EQUAL || c == C_CLOSE || c == C_QUOTE ||
                   c == C_SPACE || c == C_CR || c == C_LF);
        return c;
    endfunction

    function automatic void put_spaces(int unsigned hi);
        repeat ($urandom_range(0, hi)) pair_units.push_back(C_SPACE);
    endfunction

    // one key or value, quoted or not
    function automatic void put_token(bit is_value);
        int unsigned n;
        int unsigned gaps;
        int unsigned i;
        logic [15:0] c;
        if ($urandom_range(0, 2) == 0) begin
            pair_units.push_back(C_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n) begin
                if ($urandom_range(0, 5) == 0) begin
                    pair_units.push_back(C_QUOTE);
                    pair_units.push_back(C_QUOTE);
                end else begin
                    c = ($urandom_range(0, 5) == 0) ? special_char() : plain_char();
                    if (c == C_QUOTE) c = C_OPEN;
                    pair_units.push_back(c);
                end
            end
            pair_units.push_back(C_QUOTE);
        end else if (!(is_value && $urandom_range(0, 9) == 0)) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                if (i > 0) begin
                    // a rare long run of spaces reaches or nears the value space count limit
                    if (is_value && (force_long || $urandom_range(0, 59) == 0)) begin
                        gaps       = $urandom_range(250, 270);
                        force_long = 1'b0;
                    end else begin
                        gaps = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
                    end
                    repeat (gaps) pair_units.push_back(C_SPACE);
                end
                pair_units.push_back(plain_char());
            end
        end
    endfunction

    // a pair with random content, maybe cut short or spoiled by a bad unit
    task automatic send_pair(input bit broken);
        int unsigned cut;
        bit          tail_eot;
        pair_units.delete();
        if ($urandom_range(0, 4) == 0) pair_units.push_back(plain_char());
        pair_units.push_back(C_OPEN);
        put_spaces(2);
        put_token(1'b0);
        put_spaces(2);
        pair_units.push_back(C_EQUAL);
        put_spaces(2);
        put_token(1'b1);
        put_spaces(2);
        pair_units.push_back(C_CLOSE);
        tail_eot = ($urandom_range(0, 5) == 0);
        if (broken) begin
            cut = $urandom_range(1, pair_units.size() - 1);
            if ($urandom_range(0, 1) == 0) begin
                while (pair_units.size() > cut) void'(pair_units.pop_back());
                tail_eot = 1'b1;
            end else begin
                pair_units[cut] = $urandom_range(0, 1) ? special_char() : plain_char();
            end
        end
        foreach (pair_units[i])
            send_unit(pair_units[i], (i == pair_units.size() - 1 && tail_eot) ||
                                     ($urandom_range(0, 199) == 0));
    endtask

    // loose units outside any pair structure
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_unit($urandom_range(0, 1) ? special_char() : plain_char(),
                      $urandom_range(0, 9) == 0);
    endtask

    // main sequence
    initial begin
        int unsigned pick;
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_units[i])
            send_unit(directed_units[i][15:0], directed_units[i][16]);
        wait_drained();

        while (units_sent < N_UNITS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) send_pair(1'b0);
            else if (pick < 85) send_pair(1'b1);
            else send_noise();
            if ($urandom_range(0, 39) == 0) wait_drained();
        end

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_scan.sv
rtl/kvt_outq.sv
rtl/key_value_pair_tokenizer.sv
rtl/kvt_checker.sv
test/tb_key_value_pair_tokenizer.sv
